/* hw/rtl/fbpa_pkg.sv */
// fbpa_pkg: shared types and constants of the block pool allocator
// bitmap row geometry, operation and status codes, controller states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

	// bitmap is stored as rows of WORD_W used bits
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;
	// first-free search splits a row into groups
	localparam int GRP_W    = 8;
	localparam int GRP_N    = WORD_W / GRP_W;
	localparam int GRP_BITS = 3;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_BIG   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_ALLOC = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_DONE
	} fsm_state_t;

endpackage : fbpa_pkg

`default_nettype wire

/* hw/rtl/fbpa_ram.sv */
// fbpa_ram: generic single write, single read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : fbpa_ram

`default_nettype wire

/* hw/rtl/fbpa_find.sv */
// fbpa_find: lowest set bit of one bitmap row, two-level group search
// depends on fbpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbpa_find (
	input  wire logic [fbpa_pkg::WORD_W-1:0] vec,
	output logic                             found,
	output logic [fbpa_pkg::BIT_W-1:0]       pos
);
	import fbpa_pkg::*;

	logic [GRP_N-1:0]    grp_any;
	logic [GRP_BITS-1:0] grp_pos [GRP_N];
	logic [BIT_W-1:0]    sel;

	// per group: lowest set bit, groups independent
	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_any[g] = |vec[g*GRP_W +: GRP_W];
			grp_pos[g] = '0;
			for (int i = GRP_W - 1; i >= 0; i--) begin
				if (vec[g*GRP_W + i]) begin
					grp_pos[g] = GRP_BITS'(i);
				end
			end
		end
	end

	// pick the lowest group that has a set bit
	always_comb begin
		sel = '0;
		for (int g = GRP_N - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				sel = BIT_W'({g[BIT_W-GRP_BITS-1:0], grp_pos[g]});
			end
		end
	end

	assign found = |grp_any;
	assign pos   = sel;

endmodule : fbpa_find

`default_nettype wire

/* hw/rtl/fixed_block_pool_allocator_core.sv */
// fixed_block_pool_allocator_core: top level of the block pool allocator
// path: a refused request goes straight to S_DONE, a free passes S_FREE_CHK, an
//   allocate scans the ROWS bitmap rows in S_SCAN (ROWS = NUM_BLOCKS/32 rounded up)
// throughput: one item at a time; the scan reads one 32-bit bitmap row a cycle
//   from the bitmap ram, which sets the allocate time
// reset: control state cleared; per-row valid bits make the bitmap read all free
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_core #(
	parameter int NUM_BLOCKS  = 128,
	parameter int BLOCK_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] request_size,
	input  wire logic [6:0]  free_index,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [6:0]       granted_index,
	output logic [7:0]       blocks_in_use
);
	import fbpa_pkg::*;

	// bitmap geometry
	localparam int ROWS   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FULL_W = ROW_W + BIT_W;
	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
	// scan passes: start row from start bit, the other rows, start row below start bit
	localparam int PASS_W = $clog2(ROWS + 1);

	fsm_state_t state_q, state_nx;

	// control state
	logic              hint_valid_q;
	logic [IDX_W-1:0]  hint_q;
	logic [IDX_W-1:0]  rot_q;
	logic [CNT_W-1:0]  count_q;
	logic [ROWS-1:0]   row_valid_q;
	logic              out_valid_q;

	// per-item working registers
	logic [ROW_W-1:0]  row_q;
	logic [BIT_W-1:0]  start_bit_q;
	logic [PASS_W-1:0] pass_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [BIT_W-1:0]  free_bit_q;
	status_t           res_status_q;
	logic [FULL_W-1:0] res_index_q;

	// output register
	status_t           out_status_q;
	logic [6:0]        out_index_q;
	logic [7:0]        out_count_q;

	// ram ports
	logic              ram_we, ram_re;
	logic [ROW_W-1:0]  ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	// request decode
	logic              accept;
	logic              is_alloc;
	logic              too_big;
	logic              pool_full;
	logic              bad_index;
	logic [IDX_W-1:0]  search_start;
	logic [FULL_W-1:0] start_full;
	logic [FULL_W-1:0] fidx_full;

	// scan datapath
	logic [WORD_W-1:0] row_data;
	logic [WORD_W-1:0] pad_mask;
	logic [WORD_W-1:0] ge_mask;
	logic [WORD_W-1:0] free_vec;
	logic              found;
	logic [BIT_W-1:0]  found_pos;
	logic [ROW_W-1:0]  row_next;
	logic              last_pass;
	logic              free_hit;
	logic              out_load;
	logic [FULL_W:0]   pad_idx;

	assign accept    = in_valid && in_ready;
	assign is_alloc  = (op == OP_ALLOC);
	assign too_big   = (request_size > 16'(BLOCK_BYTES));
	assign pool_full = (count_q >= CNT_W'(NUM_BLOCKS));
	assign bad_index = (32'(free_index) >= NUM_BLOCKS);

	// pending hint wins over the rotating start
	assign search_start = hint_valid_q ? hint_q : rot_q;
	assign start_full   = FULL_W'(search_start);
	assign fidx_full    = FULL_W'(free_index);

	// rows never written read as all free
	assign row_data  = row_valid_q[row_q] ? ram_rdata : '0;
	assign row_next  = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
	assign last_pass = (pass_q == PASS_W'(ROWS));
	assign ge_mask   = {WORD_W{1'b1}} << start_bit_q;
	assign free_hit  = row_data[free_bit_q];

	// bits beyond the pool in the last row count as used
	always_comb begin
		pad_mask = '0;
		pad_idx  = '0;
		for (int j = 0; j < WORD_W; j++) begin
			pad_idx     = {1'b0, row_q, BIT_W'(j)};
			pad_mask[j] = (pad_idx >= (FULL_W + 1)'(NUM_BLOCKS));
		end
	end

	// first pass looks from the start bit up, the closing pass below it
	always_comb begin
		free_vec = ~(row_data | pad_mask);
		if (pass_q == '0) begin
			free_vec = free_vec & ge_mask;
		end else if (last_pass) begin
			free_vec = free_vec & ~ge_mask;
		end
	end

	fbpa_find u_find (
		.vec   (free_vec),
		.found (found),
		.pos   (found_pos)
	);

	fbpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS),
		.AW    (ROW_W)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_alloc && !too_big && !pool_full) begin
						state_nx = S_SCAN;
					end else if (!is_alloc && !bad_index) begin
						state_nx = S_FREE_CHK;
					end else begin
						state_nx = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (found || last_pass) begin
					state_nx = S_DONE;
				end
			end
			S_FREE_CHK: state_nx = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state-dependent outputs: handshake and ram control
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = row_next;
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = row_data | (WORD_W'(1) << found_pos);
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (is_alloc) begin
						ram_re    = !too_big && !pool_full;
						ram_raddr = start_full[FULL_W-1:BIT_W];
					end else begin
						ram_re    = !bad_index;
						ram_raddr = fidx_full[FULL_W-1:BIT_W];
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					ram_we = 1'b1;
				end else if (!last_pass) begin
					ram_re = 1'b1;
				end
			end
			S_FREE_CHK: begin
				ram_we    = free_hit;
				ram_wdata = row_data & ~(WORD_W'(1) << free_bit_q);
			end
			S_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hint_valid_q <= 1'b0;
			hint_q       <= '0;
			rot_q        <= '0;
			count_q      <= '0;
			row_valid_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ram_we) begin
				row_valid_q[ram_waddr] <= 1'b1;
			end
			// hint or rotation consumed once the search is committed
			if (state_q == S_IDLE && accept && is_alloc && !too_big && !pool_full) begin
				if (hint_valid_q) begin
					hint_valid_q <= 1'b0;
				end else if (rot_q == IDX_W'(NUM_BLOCKS - 1)) begin
					rot_q <= '0;
				end else begin
					rot_q <= rot_q + 1'b1;
				end
			end
			if (state_q == S_SCAN && found) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_FREE_CHK && free_hit) begin
				hint_valid_q <= 1'b1;
				hint_q       <= free_idx_q;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pass_q      <= '0;
				res_index_q <= '0;
				free_idx_q  <= IDX_W'(fidx_full);
				free_bit_q  <= fidx_full[BIT_W-1:0];
				if (is_alloc) begin
					row_q       <= start_full[FULL_W-1:BIT_W];
					start_bit_q <= start_full[BIT_W-1:0];
					res_status_q <= too_big ? STAT_TOO_BIG : STAT_FULL;
				end else begin
					row_q        <= fidx_full[FULL_W-1:BIT_W];
					res_status_q <= STAT_NOT_ALLOC;
				end
			end
			S_SCAN: begin
				if (found) begin
					res_status_q <= STAT_OK;
					res_index_q  <= {row_q, found_pos};
				end else begin
					// a search that finds nothing keeps the full status
					row_q  <= row_next;
					pass_q <= pass_q + 1'b1;
				end
			end
			S_FREE_CHK: begin
				if (free_hit) begin
					res_status_q <= STAT_OK;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= 7'(res_index_q);
			out_count_q  <= 8'(count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_index = out_index_q;
	assign blocks_in_use = out_count_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_BLOCKS))
		else $error("used count beyond pool size");

	a_grant_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found) |-> (count_q < CNT_W'(NUM_BLOCKS)))
		else $error("grant while pool full");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SCAN || state_q == S_FREE_CHK))
		else $error("bitmap write outside scan or free check");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("bitmap read and write in one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken while busy");

endmodule : fixed_block_pool_allocator_core

`default_nettype wire
